[hw/rtl/led_color_linear_smoother_core_macros.svh]
// assertion macros for the led color smoother core
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef LED_COLOR_LINEAR_SMOOTHER_CORE_MACROS_SVH
`define LED_COLOR_LINEAR_SMOOTHER_CORE_MACROS_SVH

// same-cycle implication
`define LCS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lcs_pkg.sv]
// shared types and codes of the led color smoother
// no dependencies
package lcs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_WR,
        ST_CLR_TGT,
        ST_CLR_DLY,
        ST_OFF
    } t_state;

    typedef enum logic [1:0] {
        Q_DIRECT,
        Q_IN,
        Q_OUT
    } t_qmode;

    localparam logic [1:0] OP_TARGET = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_OFF    = 2'd2;

    localparam logic [1:0] CFG_SETTLE = 2'd0;
    localparam logic [1:0] CFG_DELAY  = 2'd1;
    localparam logic [1:0] CFG_CONT   = 2'd2;
    localparam logic [1:0] CFG_COUNT  = 2'd3;

    localparam logic [15:0] SETTLE_RST = 16'd200;
    localparam logic [6:0]  COUNT_RST  = 7'd64;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

endpackage

[hw/rtl/lcs_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module lcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hw/rtl/lcs_div.sv]
// restoring divider for the smoothing factor, one quotient bit per cycle
// depends on lcs_pkg
module lcs_div import lcs_pkg::*; #(
    parameter int K_FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_div_req               i_req,
    output logic                   o_done,
    output logic [K_FRAC_BITS-1:0] o_quot
);

    localparam int CW = $clog2(K_FRAC_BITS + 1);

    logic [32:0]            r_rem, n_rem;
    logic [31:0]            r_den;
    logic [K_FRAC_BITS-1:0] r_quot, n_quot;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [32:0]            shifted;

    // numerator is below the divisor, so the remainder fits in 33 bits
    always_comb begin
        shifted = {r_rem[31:0], 1'b0};
        if (shifted >= {1'b0, r_den}) begin
            n_rem  = shifted - {1'b0, r_den};
            n_quot = {r_quot[K_FRAC_BITS-2:0], 1'b1};
        end else begin
            n_rem  = shifted;
            n_quot = {r_quot[K_FRAC_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(K_FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {1'b0, i_req.num};
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[hw/rtl/led_color_linear_smoother_core.sv]
// led color smoother top level: control sequencer, color memories, delay store
// depends on lcs_pkg, lcs_ram, lcs_div and led_color_linear_smoother_core_macros.svh
//
//  channel  direction  handshake                   payload
//  in       sink       i_in_valid / o_in_ready     op, led index, rgb, frame end, time
//  out      source     o_out_valid / i_out_ready   led index, rgb, frame last, off
//  cfg      sink       i_cfg_we                    register index, data
//
//  target item, ignored tick or unknown op: accepted and handled in the idle state
//  tick: a divider run for k (skipped when k is fixed), then, for each of the
//  NUM_LEDS leds, a color and delay memory read followed by a write
//  continuous switch off: clear all targets, then clear the delay slots of each queued frame
//  reset is synchronous active low; color and delay memories are not cleared
//  a stalled output transfer holds the led walk in place
module led_color_linear_smoother_core import lcs_pkg::*; #(
    parameter int NUM_LEDS    = 64,
    parameter int DELAY_MAX   = 8,
    parameter int K_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_led_index,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic        i_frame_end,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_led_out_index,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic        o_frame_last,
    output logic        o_device_off,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

`include "led_color_linear_smoother_core_macros.svh"

    localparam int IW  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int HW  = (DELAY_MAX > 1) ? $clog2(DELAY_MAX) : 1;
    localparam int FW  = $clog2(DELAY_MAX + 1);
    localparam int SW  = FW + 1;
    localparam int DD  = DELAY_MAX * NUM_LEDS;
    localparam int DA  = (DD > 1) ? $clog2(DD) : 1;
    localparam int KW  = K_FRAC_BITS + 1;
    localparam logic [KW+8:0] KRND    = (KW+9)'((1 << K_FRAC_BITS) - 1);
    localparam logic [KW-1:0] K_ONE   = KW'(1 << K_FRAC_BITS);
    localparam logic [IW-1:0] IDX_END = IW'(NUM_LEDS - 1);

    // state
    t_state           r_state, n_state;
    t_qmode           r_mode, n_mode;
    logic [IW-1:0]    r_idx, n_idx;
    logic [FW-1:0]    r_clr, n_clr;
    logic [HW-1:0]    r_head, n_head;
    logic [FW-1:0]    r_fill, n_fill;
    logic [HW-1:0]    r_wslot, n_wslot;
    logic [31:0]      r_deadline, n_deadline;
    logic [31:0]      r_last, n_last;
    logic             r_running, n_running;
    logic             r_init, n_init;
    logic             r_snap, n_snap;
    logic [KW-1:0]    r_k, n_k;

    // configuration
    logic [15:0]      r_settle;
    logic [3:0]       r_delay;
    logic             r_cont;
    logic [6:0]       r_count;

    // output register
    logic             r_ov, n_ov;
    logic [5:0]       r_oidx, n_oidx;
    logic [23:0]      r_ocol, n_ocol;
    logic             r_olast, n_olast;
    logic             r_ooff, n_ooff;

    // memories
    logic             tgt_we, cur_we, dly_we;
    logic [IW-1:0]    tgt_wa, cur_wa;
    logic [DA-1:0]    dly_wa, dly_ra;
    logic [23:0]      tgt_wd, cur_wd, dly_wd;
    logic [23:0]      tgt_rd, cur_rd, dly_rd;

    t_div_req         div_req;
    logic             div_done;
    logic [K_FRAC_BITS-1:0] div_quot;

    logic             in_fire, out_free;
    logic [31:0]      delta, den;
    logic             snap_now, run_after;
    logic [4:0]       eff_delay;
    logic [6:0]       eff_count, idx_ext;
    logic             emit_now, proceed, last_led;
    logic [23:0]      new_col;
    logic [HW-1:0]    slot_next, clr_slot;

    function automatic logic [HW-1:0] slot_wrap(input logic [SW-1:0] sum);
        logic [SW-1:0] w;
        begin
            w = (sum >= SW'(DELAY_MAX)) ? sum - SW'(DELAY_MAX) : sum;
            return HW'(w);
        end
    endfunction

    function automatic logic [DA-1:0] dly_addr(input logic [HW-1:0] slot,
                                                input logic [IW-1:0] idx);
        begin
            return DA'(DA'(slot) * DA'(NUM_LEDS)) + DA'(idx);
        end
    endfunction

    // step one component by ceil(k * |diff|)
    function automatic logic [7:0] step_comp(input logic [7:0] c, input logic [7:0] t,
                                             input logic [KW-1:0] k);
        logic [7:0]    ad;
        logic [KW+8:0] pr;
        logic [7:0]    st;
        begin
            ad = (t >= c) ? t - c : c - t;
            pr = (KW+9)'(k) * (KW+9)'(ad) + KRND;
            st = pr[K_FRAC_BITS+7:K_FRAC_BITS];
            return (t >= c) ? c + st : c - st;
        end
    endfunction

    lcs_ram #(.WIDTH(24), .DEPTH(NUM_LEDS)) u_tgt (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_wa), .i_wdata(tgt_wd),
        .i_raddr(r_idx), .o_rdata(tgt_rd)
    );

    lcs_ram #(.WIDTH(24), .DEPTH(NUM_LEDS)) u_cur (
        .i_clk(i_clk), .i_we(cur_we), .i_waddr(cur_wa), .i_wdata(cur_wd),
        .i_raddr(r_idx), .o_rdata(cur_rd)
    );

    lcs_ram #(.WIDTH(24), .DEPTH(DD)) u_dly (
        .i_clk(i_clk), .i_we(dly_we), .i_waddr(dly_wa), .i_wdata(dly_wd),
        .i_raddr(dly_ra), .o_rdata(dly_rd)
    );

    lcs_div #(.K_FRAC_BITS(K_FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_quot(div_quot)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_ov || i_out_ready;

    // tick timing: remaining time to the deadline and interval from the last tick to the deadline
    assign delta     = r_deadline - i_now_ms;
    assign den       = r_deadline - r_last;
    assign snap_now  = delta[31];
    assign run_after = snap_now ? r_cont : 1'b1;
    assign eff_delay = ({1'b0, r_delay} > 5'(DELAY_MAX)) ? 5'(DELAY_MAX) : {1'b0, r_delay};
    assign eff_count = (r_count == 7'd0) ? 7'd1 :
                       (r_count > 7'(NUM_LEDS)) ? 7'(NUM_LEDS) : r_count;
    assign slot_next = slot_wrap(SW'(r_head) + SW'(r_fill));
    assign clr_slot  = slot_wrap(SW'(r_head) + SW'(r_clr));

    // led walk datapath
    assign idx_ext  = 7'(r_idx);
    assign last_led = (r_idx == IDX_END);
    assign emit_now = (r_mode != Q_IN) && (idx_ext < eff_count);
    assign proceed  = !emit_now || out_free;
    assign new_col  = r_snap ? tgt_rd :
                      {step_comp(cur_rd[23:16], tgt_rd[23:16], r_k),
                       step_comp(cur_rd[15:8],  tgt_rd[15:8],  r_k),
                       step_comp(cur_rd[7:0],   tgt_rd[7:0],   r_k)};
    assign dly_ra   = dly_addr(r_head, r_idx);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_op)
                        OP_TICK: begin
                            if (r_running) begin
                                n_state = (snap_now || den == 32'd0 || den[31] ||
                                           delta >= den || delta == 32'd0) ? ST_RD : ST_DIV;
                            end
                        end
                        OP_OFF: begin
                            n_state = r_cont ? ST_CLR_TGT : ST_OFF;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                if (proceed) begin
                    n_state = last_led ? ST_IDLE : ST_RD;
                end
            end
            ST_CLR_TGT: begin
                if (last_led) begin
                    n_state = (r_fill == '0) ? ST_IDLE : ST_CLR_DLY;
                end
            end
            ST_CLR_DLY: begin
                if (last_led && (r_clr + 1'b1 == r_fill)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_OFF: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath, memory ports and output register
    always_comb begin
        n_mode     = r_mode;
        n_idx      = r_idx;
        n_clr      = r_clr;
        n_head     = r_head;
        n_fill     = r_fill;
        n_wslot    = r_wslot;
        n_deadline = r_deadline;
        n_last     = r_last;
        n_running  = r_running;
        n_init     = r_init;
        n_snap     = r_snap;
        n_k        = r_k;
        n_ov       = r_ov && !i_out_ready;
        n_oidx     = r_oidx;
        n_ocol     = r_ocol;
        n_olast    = r_olast;
        n_ooff     = r_ooff;
        tgt_we     = 1'b0;
        tgt_wa     = r_idx;
        tgt_wd     = '0;
        cur_we     = 1'b0;
        cur_wa     = r_idx;
        cur_wd     = new_col;
        dly_we     = 1'b0;
        dly_wa     = dly_addr(r_wslot, r_idx);
        dly_wd     = new_col;
        div_req    = '{start: 1'b0, num: den - delta, den: den};
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_op)
                        OP_TARGET: begin
                            tgt_wa = IW'(i_led_index);
                            tgt_wd = {i_red_in, i_green_in, i_blue_in};
                            cur_wa = IW'(i_led_index);
                            cur_wd = {i_red_in, i_green_in, i_blue_in};
                            if (7'(i_led_index) < 7'(NUM_LEDS)) begin
                                tgt_we = 1'b1;
                                cur_we = !r_init;
                            end
                            if (i_frame_end) begin
                                n_deadline = i_now_ms + 32'(r_settle);
                                n_running  = 1'b1;
                                if (!r_init) begin
                                    n_last = i_now_ms;
                                    n_init = 1'b1;
                                end
                            end
                        end
                        OP_TICK: begin
                            if (r_running) begin
                                n_idx     = '0;
                                n_snap    = snap_now;
                                n_last    = i_now_ms;
                                n_running = run_after;
                                n_wslot   = slot_next;
                                if (eff_delay == 5'd0) begin
                                    n_mode = Q_DIRECT;
                                end else if ((5'(r_fill) >= eff_delay) || !run_after) begin
                                    n_mode = (r_fill == '0) ? Q_DIRECT : Q_OUT;
                                end else begin
                                    n_mode = Q_IN;
                                end
                                // full step also when the tick lands on the deadline
                                if (den == 32'd0 || den[31] || delta == 32'd0) begin
                                    n_k = K_ONE;
                                end else if (delta >= den) begin
                                    n_k = '0;
                                end else begin
                                    div_req.start = !snap_now;
                                end
                            end
                        end
                        OP_OFF: begin
                            if (r_cont) begin
                                n_deadline = '0;
                                n_running  = 1'b1;
                                n_idx      = '0;
                                n_clr      = '0;
                            end else begin
                                n_running = 1'b0;
                            end
                        end
                        default: begin
                            n_running = r_running;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_k = {1'b0, div_quot};
                end
            end
            ST_RD: begin
                n_idx = r_idx;
            end
            ST_WR: begin
                if (proceed) begin
                    cur_we = 1'b1;
                    dly_we = (r_mode != Q_DIRECT);
                    if (emit_now) begin
                        n_ov    = 1'b1;
                        n_oidx  = 6'(r_idx);
                        n_ocol  = (r_mode == Q_OUT) ? dly_rd : new_col;
                        n_olast = (idx_ext + 7'd1 == eff_count);
                        n_ooff  = 1'b0;
                    end
                    if (last_led) begin
                        if (r_mode == Q_IN) begin
                            n_fill = r_fill + 1'b1;
                        end else if (r_mode == Q_OUT) begin
                            n_head = slot_wrap(SW'(r_head) + SW'(1));
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_CLR_TGT: begin
                tgt_we = 1'b1;
                n_idx  = last_led ? '0 : r_idx + 1'b1;
            end
            ST_CLR_DLY: begin
                dly_we = 1'b1;
                dly_wa = dly_addr(clr_slot, r_idx);
                dly_wd = '0;
                if (last_led) begin
                    n_idx = '0;
                    n_clr = r_clr + 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_OFF: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_oidx  = '0;
                    n_ocol  = '0;
                    n_olast = 1'b0;
                    n_ooff  = 1'b1;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_fill     <= '0;
            r_deadline <= '0;
            r_last     <= '0;
            r_running  <= 1'b0;
            r_init     <= 1'b0;
            r_ov       <= 1'b0;
            r_settle   <= SETTLE_RST;
            r_delay    <= '0;
            r_cont     <= 1'b0;
            r_count    <= COUNT_RST;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_fill     <= n_fill;
            r_deadline <= n_deadline;
            r_last     <= n_last;
            r_running  <= n_running;
            r_init     <= n_init;
            r_ov       <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SETTLE: r_settle <= i_cfg_data;
                    CFG_DELAY:  r_delay  <= i_cfg_data[3:0];
                    CFG_CONT:   r_cont   <= i_cfg_data[0];
                    CFG_COUNT:  r_count  <= i_cfg_data[6:0];
                    default:    r_count  <= r_count;
                endcase
            end
        end
    end

    // payload and walk registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_idx   <= n_idx;
        r_clr   <= n_clr;
        r_wslot <= n_wslot;
        r_snap  <= n_snap;
        r_k     <= n_k;
        r_oidx  <= n_oidx;
        r_ocol  <= n_ocol;
        r_olast <= n_olast;
        r_ooff  <= n_ooff;
    end

    assign o_out_valid     = r_ov;
    assign o_led_out_index = r_oidx;
    assign o_red_out       = r_ocol[23:16];
    assign o_green_out     = r_ocol[15:8];
    assign o_blue_out      = r_ocol[7:0];
    assign o_frame_last    = r_olast;
    assign o_device_off    = r_ooff;

    `LCS_ASSERT_IMPL(a_fill_bound, 1'b1, r_fill <= FW'(DELAY_MAX), "queue fill above depth")
    `LCS_ASSERT_IMPL(a_off_black, r_ov && r_ooff, r_ocol == '0 && !r_olast,
                     "off command carries color")
    `LCS_ASSERT_NEXT(a_emit_loads, r_state == ST_WR && proceed && emit_now, r_ov,
                     "emitted led not registered")
    `LCS_ASSERT_NEXT(a_div_wait, r_state == ST_DIV && !div_done, r_state == ST_DIV,
                     "left divide before quotient")

endmodule
